// ===== hw/rtl/psw_pkg.sv =====
`default_nettype none

package psw_pkg;

    // Field widths
    localparam int ID_W      = 8;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 20;
    localparam int TOTAL_W   = 24;
    localparam int FRAC_W    = 8;
    localparam int AVG_W     = 28;

    // Divider: dividend is total << FRAC_W, one quotient bit per step
    localparam int DIV_STEPS = TOTAL_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Stream payload widths
    localparam int S_DATA_W  = ID_W + BURST_W + PRIO_W;
    localparam int M_DATA_W  = ID_W + BURST_W + PRIO_W + 2 * TIME_W + 2 * AVG_W;

    // One stored job, packed like the input tdata (id in the low bits)
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT,
        S_DIV,
        S_EMIT_LAST
    } state_t;

    typedef struct packed {
        logic load_en;
        logic scan_init;
        logic scan_run;
        logic swap_first;
        logic swap_second;
        logic out_load;
        logic out_load_last;
        logic next_pos;
        logic div_start;
        logic div_run;
        logic clear_set;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic last_pos;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psw_ctrl.sv =====
`default_nettype none

module psw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    input  wire psw_pkg::status_t  status,
    output psw_pkg::cmd_t          cmd
);

    psw_pkg::state_t state_reg;
    psw_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psw_pkg::S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psw_pkg::S_LOAD: begin
                if (s_tvalid && s_tlast) state_next = psw_pkg::S_SCAN;
            end
            psw_pkg::S_SCAN: begin
                if (status.scan_done) state_next = psw_pkg::S_SWAP_A;
            end
            psw_pkg::S_SWAP_A: begin
                state_next = psw_pkg::S_SWAP_B;
            end
            psw_pkg::S_SWAP_B: begin
                state_next = psw_pkg::S_EMIT;
            end
            psw_pkg::S_EMIT: begin
                if (status.last_pos) begin
                    state_next = psw_pkg::S_DIV;
                end else if (status.out_free) begin
                    state_next = psw_pkg::S_SCAN;
                end
            end
            psw_pkg::S_DIV: begin
                if (status.div_done) state_next = psw_pkg::S_EMIT_LAST;
            end
            psw_pkg::S_EMIT_LAST: begin
                if (status.out_free) state_next = psw_pkg::S_LOAD;
            end
            default: begin
                state_next = psw_pkg::S_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            psw_pkg::S_LOAD: begin
                s_tready      = 1'b1;
                cmd.load_en   = s_tvalid;
                cmd.scan_init = s_tvalid && s_tlast;
            end
            psw_pkg::S_SCAN: begin
                cmd.scan_run = 1'b1;
            end
            psw_pkg::S_SWAP_A: begin
                cmd.swap_first = 1'b1;
            end
            psw_pkg::S_SWAP_B: begin
                cmd.swap_second = 1'b1;
            end
            psw_pkg::S_EMIT: begin
                if (status.last_pos) begin
                    cmd.div_start = 1'b1;
                end else if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.next_pos  = 1'b1;
                    cmd.scan_init = 1'b1;
                end
            end
            psw_pkg::S_DIV: begin
                cmd.div_run = 1'b1;
            end
            psw_pkg::S_EMIT_LAST: begin
                if (status.out_free) begin
                    cmd.out_load_last = 1'b1;
                    cmd.clear_set     = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/psw_datapath.sv =====
`default_nettype none

module psw_datapath #(
    parameter int MAX_JOBS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [psw_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire psw_pkg::cmd_t                  cmd,
    output psw_pkg::status_t                    status,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [psw_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

    // Job memory: one write and one registered read per cycle
    psw_pkg::entry_t job_mem [MAX_JOBS];
    psw_pkg::entry_t rdata_reg;

    logic            mem_we;
    logic [IDX_W-1:0] mem_waddr;
    psw_pkg::entry_t mem_wdata;

    // Control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             v_reg, v_next;
    logic [psw_pkg::TIME_W-1:0]  run_reg, run_next;
    logic [psw_pkg::TOTAL_W-1:0] wsum_reg, wsum_next;
    logic [psw_pkg::TOTAL_W-1:0] tsum_reg, tsum_next;
    logic [psw_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    logic [IDX_W-1:0] idx_reg;
    psw_pkg::entry_t  best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    psw_pkg::entry_t  first_reg;
    logic [psw_pkg::TIME_W-1:0] cur_w_reg;
    logic [psw_pkg::TIME_W-1:0] cur_t_reg;
    logic [psw_pkg::DIV_STEPS-1:0] wq_reg;
    logic [psw_pkg::DIV_STEPS-1:0] tq_reg;
    logic [CNT_W-1:0] wr_reg;
    logic [CNT_W-1:0] tr_reg;
    logic [psw_pkg::M_DATA_W-1:0] out_data_reg;
    logic             out_user_reg;
    logic             out_last_reg;

    logic store_full;
    logic issue;
    logic div_step;
    logic [psw_pkg::TIME_W-1:0] turn_sum;
    logic [CNT_W:0] w_shift, t_shift;
    logic           w_ge, t_ge;
    logic [CNT_W-1:0] w_rem, t_rem;

    assign store_full = (count_reg == MAX_CNT);
    assign issue      = cmd.scan_run && (j_reg < count_reg);
    assign div_step   = cmd.div_run && (div_cnt_reg != '0);
    assign turn_sum   = run_reg + psw_pkg::TIME_W'(best_reg.burst);

    // Memory write select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = psw_pkg::entry_t'(s_tdata);
        if (cmd.load_en && !store_full) begin
            mem_we = 1'b1;
        end else if (cmd.swap_first) begin
            mem_we    = 1'b1;
            mem_waddr = pos_reg;
            mem_wdata = best_reg;
        end else if (cmd.swap_second) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = first_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) job_mem[mem_waddr] <= mem_wdata;
        if (issue)  rdata_reg <= job_mem[j_reg[IDX_W-1:0]];
    end

    // Restoring divide steps, both averages side by side
    always_comb begin
        w_shift = {wr_reg, wq_reg[psw_pkg::DIV_STEPS-1]};
        t_shift = {tr_reg, tq_reg[psw_pkg::DIV_STEPS-1]};
        w_ge    = (w_shift >= {1'b0, count_reg});
        t_ge    = (t_shift >= {1'b0, count_reg});
        w_rem   = w_ge ? CNT_W'(w_shift - {1'b0, count_reg}) : w_shift[CNT_W-1:0];
        t_rem   = t_ge ? CNT_W'(t_shift - {1'b0, count_reg}) : t_shift[CNT_W-1:0];
    end

    always_comb begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        v_next         = issue;
        run_next       = run_reg;
        wsum_next      = wsum_reg;
        tsum_next      = tsum_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load_en) begin
            if (store_full) ovf_next = 1'b1;
            else            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.next_pos) pos_next = pos_reg + IDX_W'(1);
        if (issue)        j_next = j_reg + CNT_W'(1);
        if (cmd.scan_init) begin
            j_next = CNT_W'(pos_next);
            v_next = 1'b0;
        end
        if (cmd.swap_second) begin
            run_next  = turn_sum;
            wsum_next = wsum_reg + psw_pkg::TOTAL_W'(run_reg);
            tsum_next = tsum_reg + psw_pkg::TOTAL_W'(turn_sum);
        end
        if (cmd.div_start)     div_cnt_next = psw_pkg::DIV_CNT_W'(psw_pkg::DIV_STEPS);
        else if (div_step)     div_cnt_next = div_cnt_reg - psw_pkg::DIV_CNT_W'(1);
        if (cmd.out_load || cmd.out_load_last) out_valid_next = 1'b1;
        else if (m_tready)                     out_valid_next = 1'b0;
        if (cmd.clear_set) begin
            count_next = '0;
            ovf_next   = 1'b0;
            pos_next   = '0;
            run_next   = '0;
            wsum_next  = '0;
            tsum_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            j_reg         <= '0;
            v_reg         <= 1'b0;
            run_reg       <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            v_reg         <= v_next;
            run_reg       <= run_next;
            wsum_reg      <= wsum_next;
            tsum_reg      <= tsum_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) idx_reg <= j_reg[IDX_W-1:0];

        // First entry of the pass seeds the minimum; strict less keeps first index
        if (cmd.scan_run && v_reg) begin
            if (idx_reg == pos_reg) begin
                best_reg     <= rdata_reg;
                best_idx_reg <= idx_reg;
                first_reg    <= rdata_reg;
            end else if (rdata_reg.prio < best_reg.prio) begin
                best_reg     <= rdata_reg;
                best_idx_reg <= idx_reg;
            end
        end

        if (cmd.swap_second) begin
            cur_w_reg <= run_reg;
            cur_t_reg <= turn_sum;
        end

        if (cmd.div_start) begin
            wq_reg <= {wsum_next, psw_pkg::FRAC_W'(0)};
            tq_reg <= {tsum_next, psw_pkg::FRAC_W'(0)};
            wr_reg <= '0;
            tr_reg <= '0;
        end else if (div_step) begin
            wq_reg <= {wq_reg[psw_pkg::DIV_STEPS-2:0], w_ge};
            tq_reg <= {tq_reg[psw_pkg::DIV_STEPS-2:0], t_ge};
            wr_reg <= w_rem;
            tr_reg <= t_rem;
        end

        if (cmd.out_load) begin
            out_data_reg <= {psw_pkg::AVG_W'(0), psw_pkg::AVG_W'(0),
                             cur_t_reg, cur_w_reg, best_reg};
            out_user_reg <= ovf_reg;
            out_last_reg <= 1'b0;
        end else if (cmd.out_load_last) begin
            out_data_reg <= {tq_reg[psw_pkg::AVG_W-1:0], wq_reg[psw_pkg::AVG_W-1:0],
                             cur_t_reg, cur_w_reg, best_reg};
            out_user_reg <= ovf_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign status.scan_done = (j_reg == count_reg) && !v_reg;
    assign status.last_pos  = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);
    assign status.div_done  = (div_cnt_reg == '0);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_schedule_wait_times_top.sv =====
`default_nettype none

// Nonpreemptive priority scheduler. Jobs stream in one transaction per cycle
// on the s_ side (id, burst, priority; tlast marks the final job of a set)
// and are kept in a MAX_JOBS-deep job memory; jobs past that depth are
// dropped and every result of the set then carries tuser = 1. After the
// tlast transaction the block orders the set by selection sort on priority
// (smallest first, the first index wins a tie, swaps make it unstable) and
// sends one m_ transaction per job with its wait and turnaround times. The
// final result carries tlast and both averages as unsigned fixed point with
// 8 fraction bits, truncated; on all other results the averages are zero.
// Flow: for each position the job memory, with its single read port, is
// scanned once, and two swap writes follow; after the last position a
// 32-step restoring divider forms both averages. No new job is taken until
// the final result sits in the output register; m_tready back pressure
// stalls the sort at each emitted result.

module priority_schedule_wait_times_top #(
    parameter int MAX_JOBS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // tdata: process_id[7:0], burst_time[23:8], priority_level[31:24]
    input  wire logic [psw_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tlast,   // is_last
    input  wire logic                           s_tvalid,
    output logic                                s_tready,

    // tdata: job_id[7:0], job_burst[23:8], job_priority[31:24],
    //        wait_time[51:32], turnaround_time[71:52],
    //        avg_wait_fixed[99:72], avg_turnaround_fixed[127:100]
    output logic [psw_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tuser,   // overflow_seen
    output logic                                m_tlast,   // last_result
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    psw_pkg::cmd_t    cmd;
    psw_pkg::status_t status;

    // Sequencer: load, per-position scan/swap/emit, divide, final emit
    psw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Job memory, running sums, divider and output register
    psw_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/psw_checker.sv =====
`default_nettype none

module psw_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         s_tlast,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [psw_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);

    logic [psw_pkg::TIME_W-1:0] turn_expect;

    assign turn_expect = m_tdata[51:32] + psw_pkg::TIME_W'(m_tdata[23:8]);

    // Held result does not change while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Final job of a set starts scheduling: no job taken in the next cycle
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted right after final job");

    // Averages only on the final result
    a_avg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[127:72] == '0)
        else $error("average nonzero on a non-final result");

    // Turnaround is wait plus own burst
    a_turnaround: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:52] == turn_expect)
        else $error("turnaround differs from wait plus burst");

endmodule

bind priority_schedule_wait_times_top psw_checker u_psw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
